/* rtl/gffp_pkg.sv */
// Shared types, codes and constants of the grid first-fit placer.
package gffp_pkg;

    // Default grid capacity.
    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 16;

    // Field widths.
    localparam int SIZE_W      = 5;
    localparam int POS_W       = 4;
    localparam int OP_W        = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // Internal coordinate and sum width; holds every column, row and end value.
    localparam int COORD_W = 7;

    // Reset value of both grid size registers.
    localparam logic [CFG_DATA_W-1:0] GRID_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_PLACE   = 2'd0,
        OP_MARK    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACC,
        ST_SCAN,
        ST_WR_RD,
        ST_WR_WR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load_item;
        logic setup_place;
        logic setup_mark;
        logic acc_step;
        logic x_next;
        logic y_next;
        logic wr_begin;
        logic wr_read;
        logic wr_write;
        logic out_load;
        logic res_found;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic bad_place;
        logic acc_done;
        logic fits;
        logic last_x;
        logic last_y;
        logic wr_more;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/gffp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gffp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/gffp_ctrl.sv */
// Sequencer of the placer: request intake, row gather, column scan, row update, result.
module gffp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_tvalid,
    output logic               o_in_tready,
    input  gffp_pkg::t_dp_stat i_stat,
    output gffp_pkg::t_dp_cmd  o_cmd
);

    gffp_pkg::t_state r_state, n_state;
    logic             r_hit, n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gffp_pkg::ST_IDLE;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_hit       = r_hit;
        o_cmd       = '0;
        o_in_tready = 1'b0;
        case (r_state)
            gffp_pkg::ST_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_hit           = 1'b0;
                    n_state         = gffp_pkg::ST_CHECK;
                end
            end
            gffp_pkg::ST_CHECK: begin
                case (i_stat.op)
                    gffp_pkg::OP_PLACE: begin
                        if (i_stat.bad_place) begin
                            n_state = gffp_pkg::ST_FIN;
                        end else begin
                            o_cmd.setup_place = 1'b1;
                            n_state           = gffp_pkg::ST_ACC;
                        end
                    end
                    gffp_pkg::OP_MARK, gffp_pkg::OP_RELEASE: begin
                        o_cmd.setup_mark = 1'b1;
                        n_hit            = 1'b1;
                        n_state          = gffp_pkg::ST_WR_RD;
                    end
                    default: begin
                        n_state = gffp_pkg::ST_FIN;
                    end
                endcase
            end
            gffp_pkg::ST_ACC: begin
                if (i_stat.acc_done) begin
                    n_state = gffp_pkg::ST_SCAN;
                end else begin
                    o_cmd.acc_step = 1'b1;
                end
            end
            gffp_pkg::ST_SCAN: begin
                if (i_stat.fits) begin
                    o_cmd.wr_begin = 1'b1;
                    n_hit          = 1'b1;
                    n_state        = gffp_pkg::ST_WR_RD;
                end else if (i_stat.last_x) begin
                    if (i_stat.last_y) begin
                        n_state = gffp_pkg::ST_FIN;
                    end else begin
                        o_cmd.y_next = 1'b1;
                        n_state      = gffp_pkg::ST_ACC;
                    end
                end else begin
                    o_cmd.x_next = 1'b1;
                end
            end
            gffp_pkg::ST_WR_RD: begin
                if (i_stat.wr_more) begin
                    o_cmd.wr_read = 1'b1;
                    n_state       = gffp_pkg::ST_WR_WR;
                end else begin
                    n_state = gffp_pkg::ST_FIN;
                end
            end
            gffp_pkg::ST_WR_WR: begin
                o_cmd.wr_write = 1'b1;
                n_state        = gffp_pkg::ST_WR_RD;
            end
            gffp_pkg::ST_FIN: begin
                o_cmd.res_found = r_hit;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = gffp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gffp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/gffp_dp.sv */
// Datapath of the placer: config, request fields, occupancy store, scan counters, result word.
module gffp_dp #(
    parameter int MAX_COLUMNS = gffp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gffp_pkg::MAX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gffp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [gffp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [gffp_pkg::OP_W-1:0]           i_in_tuser,
    input  logic [gffp_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  gffp_pkg::t_dp_cmd                   i_cmd,
    output gffp_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_tvalid,
    input  logic                                i_out_tready,
    output logic [0:0]                          o_out_tuser,
    output logic [gffp_pkg::OUT_TDATA_W-1:0]    o_out_tdata
);

    localparam int CW = gffp_pkg::COORD_W;
    localparam int SW = gffp_pkg::SIZE_W;
    localparam int PW = gffp_pkg::POS_W;
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [SW-1:0]          r_grid_w, r_grid_h;
    gffp_pkg::t_op          r_op;
    logic [SW-1:0]          r_w, r_h;
    logic [PW-1:0]          r_cx, r_cy;
    logic [CW-1:0]          r_x, r_y, r_r;
    logic [MAX_COLUMNS-1:0] r_acc;
    logic                   r_pend;
    logic                   r_rd_valid;
    logic [MAX_ROWS-1:0]    r_row_valid;
    logic                   r_out_valid, r_out_found;
    logic [PW-1:0]          r_out_x, r_out_y;

    logic [CW-1:0]          eff_cols, eff_rows, x_end, y_end;
    logic [MAX_COLUMNS-1:0] span, rd_data, rd_eff, wr_data;
    logic                   acc_issue, rd_en, set_bits;
    logic [AW-1:0]          row_addr;

    // Clip the grid registers to the storage capacity.
    assign eff_cols = (CW'(r_grid_w) > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(r_grid_w);
    assign eff_rows = (CW'(r_grid_h) > CW'(MAX_ROWS))    ? CW'(MAX_ROWS)    : CW'(r_grid_h);

    assign x_end = r_x + CW'(r_w);
    assign y_end = r_y + CW'(r_h);

    always_comb begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            span[c] = (CW'(c) >= r_x) && (CW'(c) < x_end) && (CW'(c) < eff_cols);
        end
    end

    assign acc_issue = i_cmd.acc_step && (r_r < y_end);
    assign rd_en     = acc_issue || i_cmd.wr_read;
    assign row_addr  = r_r[AW-1:0];
    assign rd_eff    = r_rd_valid ? rd_data : '0;
    assign set_bits  = (r_op != gffp_pkg::OP_RELEASE);
    assign wr_data   = set_bits ? (rd_eff | span) : (rd_eff & ~span);

    gffp_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_write),
        .i_waddr (row_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (row_addr),
        .o_rdata (rd_data)
    );

    // Config registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= gffp_pkg::GRID_RESET;
            r_grid_h <= gffp_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            case (gffp_pkg::t_cfg_idx'(i_cfg_addr))
                gffp_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                gffp_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op <= gffp_pkg::t_op'(i_in_tuser);
            r_w  <= i_in_tdata[4:0];
            r_h  <= i_in_tdata[9:5];
            r_cx <= i_in_tdata[13:10];
            r_cy <= i_in_tdata[17:14];
        end
    end

    // Scan counters and row gather.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.setup_place || i_cmd.y_next) begin
            r_pend <= 1'b0;
        end else if (i_cmd.acc_step) begin
            r_pend <= acc_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup_place) begin
            r_x   <= '0;
            r_y   <= '0;
            r_r   <= '0;
            r_acc <= '0;
        end else if (i_cmd.setup_mark) begin
            r_x <= CW'(r_cx);
            r_y <= CW'(r_cy);
            r_r <= CW'(r_cy);
        end else if (i_cmd.y_next) begin
            r_x   <= '0;
            r_y   <= r_y + CW'(1);
            r_r   <= r_y + CW'(1);
            r_acc <= '0;
        end else if (i_cmd.x_next) begin
            r_x <= r_x + CW'(1);
        end else if (i_cmd.wr_begin) begin
            r_r <= r_y;
        end else if (i_cmd.wr_write) begin
            r_r <= r_r + CW'(1);
        end else if (i_cmd.acc_step) begin
            if (acc_issue) begin
                r_r <= r_r + CW'(1);
            end
            if (r_pend) begin
                r_acc <= r_acc | rd_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_valid <= r_row_valid[row_addr];
        end
    end

    // A row never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.wr_write) begin
            r_row_valid[row_addr] <= 1'b1;
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= i_cmd.res_found;
            r_out_x     <= i_cmd.res_found ? r_x[PW-1:0] : '0;
            r_out_y     <= i_cmd.res_found ? r_y[PW-1:0] : '0;
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tuser  = r_out_found;
    assign o_out_tdata  = {r_out_y, r_out_x};

    assign o_stat.op        = r_op;
    assign o_stat.bad_place = (eff_cols == '0) || (eff_rows == '0) || (r_w == '0)
                           || (r_h == '0) || (CW'(r_w) > eff_cols) || (CW'(r_h) > eff_rows);
    assign o_stat.acc_done  = !(r_r < y_end) && !r_pend;
    assign o_stat.fits      = ((r_acc & span) == '0);
    assign o_stat.last_x    = (x_end >= eff_cols);
    assign o_stat.last_y    = (y_end >= eff_rows);
    assign o_stat.wr_more   = (r_r < y_end) && (r_r < eff_rows);
    assign o_stat.out_free  = !r_out_valid || i_out_tready;

`ifndef ASSERT_OFF
    ap_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_write |-> (r_r < eff_rows))
        else $error("row write outside grid in use");

    ap_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_tready))
        else $error("result overwritten before taken");

    ap_gather_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_step |-> !(i_cmd.wr_read || i_cmd.wr_write))
        else $error("row gather overlaps row update");

    ap_miss_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("not-found result carries a position");
`endif

endmodule

/* rtl/grid_first_fit_placer.sv */
// Top level of the grid first-fit placer: controller plus datapath.
//
// Keeps a one-bit-per-cell occupancy map of a grid of up to MAX_COLUMNS by
// MAX_ROWS cells; grid_width and grid_height (config index 0 and 1) pick the
// part in use. Write config only while idle.
// Input words: s_axis_tuser = op (place, mark, release); s_axis_tdata =
// item width, item height, cell x, cell y. Output words: m_axis_tuser = found;
// m_axis_tdata = pos x, pos y. One output word per input word, in order.
// A mark or release reads and rewrites every row it touches before its
// output word. A place gathers, for every candidate row, the h rows that
// start at it through the single RAM read port, then scans the columns
// at one position per cycle, and on a hit does a read-modify-write of each
// of those h rows.
// One word is worked on at a time; s_axis_tready is high only when idle.
// A finished word waits in the output register; if the receiver stalls and
// the register is still full, the next result holds until it drains.
// Reset: grid registers go to 16 by 16 and every cell reads as free at once
// (per-row valid bits), so no clearing pass is needed.
module grid_first_fit_placer #(
    parameter int MAX_COLUMNS = gffp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gffp_pkg::MAX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [gffp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [gffp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gffp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // item_width[4:0], item_height[9:5],
                                                               // cell_x[13:10], cell_y[17:14], zero
    input  logic [gffp_pkg::OP_W-1:0]           s_axis_tuser,  // op[1:0]
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [gffp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // pos_x[3:0], pos_y[7:4]
    output logic [0:0]                          m_axis_tuser   // found[0]
);

    gffp_pkg::t_dp_cmd  cmd;
    gffp_pkg::t_dp_stat stat;

    // Sequence each request through intake, search and update.
    gffp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold config, occupancy rows, counters and the output register.
    gffp_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_tuser   (s_axis_tuser),
        .i_in_tdata   (s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tuser  (m_axis_tuser),
        .o_out_tdata  (m_axis_tdata)
    );

endmodule
